>>> hdl/tblm_pkg.sv
// ----------------------------------------------------------------------------
// tblm_pkg
// shared types, constants and coefficient table of the three band level meter
// ----------------------------------------------------------------------------
package tblm_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int FC_W       = 13;
  localparam int SMP_W      = 32;
  localparam int SIG_W      = 40;
  localparam int SUM_W      = 48;
  localparam int LVL_W      = 24;
  localparam int COEF_W     = 33;
  localparam int MB_W       = 25;
  localparam int PROD_W     = COEF_W + MB_W;
  localparam int ACC_W      = 75;
  localparam int COEF_FRAC  = 30;
  localparam int BQ_STEPS   = 10;

  typedef enum logic [1:0] {
    REG_FRAMES_PER_BIN = 2'd0,
    REG_ENVELOPE_DECAY = 2'd1,
    REG_BIN_RECIPROCAL = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    OP_BQ_HI  = 3'd0,
    OP_BQ_LO  = 3'd1,
    OP_SUM_HI = 3'd2,
    OP_SUM_LO = 3'd3,
    OP_ENV    = 3'd4
  } op_e;

  typedef struct packed {
    logic       load;
    logic       clr;
    logic       rnd;
    logic       mul_en;
    op_e        op;
    logic [2:0] tap;
    logic [2:0] filt;
    logic [1:0] band;
    logic       bq_fin;
    logic       env_fin;
    logic       lvl_fin;
    logic       fc_inc;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic            bin_done;
    logic [FC_W-1:0] fc;
  } status_t;

  // b0, b1, b2, -a1, -a2 in q30 for lp250, hp250, lp2k, hp2k
  function automatic logic signed [COEF_W-1:0] coef(input logic [1:0] f,
                                                    input logic [2:0] k);
    logic signed [COEF_W-1:0] c;
    c = '0;
    case ({f, k})
      {2'd0, 3'd0}: c = 33'sd280947;
      {2'd0, 3'd1}: c = 33'sd561895;
      {2'd0, 3'd2}: c = 33'sd280947;
      {2'd0, 3'd3}: c = 33'sd2097799412;
      {2'd0, 3'd4}: c = -33'sd1025181378;
      {2'd1, 3'd0}: c = 33'sd1049180653;
      {2'd1, 3'd1}: c = -33'sd2098361307;
      {2'd1, 3'd2}: c = 33'sd1049180653;
      {2'd1, 3'd3}: c = 33'sd2097799412;
      {2'd1, 3'd4}: c = -33'sd1025181378;
      {2'd2, 3'd0}: c = 33'sd15463429;
      {2'd2, 3'd1}: c = 33'sd30926858;
      {2'd2, 3'd2}: c = 33'sd15463429;
      {2'd2, 3'd3}: c = 33'sd1753413056;
      {2'd2, 3'd4}: c = -33'sd741524947;
      {2'd3, 3'd0}: c = 33'sd892169957;
      {2'd3, 3'd1}: c = -33'sd1784339914;
      {2'd3, 3'd2}: c = 33'sd892169957;
      {2'd3, 3'd3}: c = 33'sd1753413056;
      {2'd3, 3'd4}: c = -33'sd741524947;
      default:      c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/three_band_level_meter.sv
// ----------------------------------------------------------------------------
// three_band_level_meter
// stereo three band level meter with peak release envelope
// ----------------------------------------------------------------------------
// usage:
//   s_axis: one stereo frame per transaction, tdata = left, right (q1.31)
//   m_axis: one bin per transaction, tdata = peak_envelope (q0.24), low_level,
//           mid_level, high_level (q1.23 each), bin_sequence
//   apb: frames_per_bin at 0x0, envelope_decay at 0x4, bin_reciprocal at 0x8
// frames: one frame at a time; ten products per biquad on the one shared
//   33x25 multiplier, eight biquads per frame
// reset: filter history, sums, peak, envelope and counters clear at once,
//   registers return to 294 / 64212 / 57065, no clearing pass
// stall: a finished bin waits in the output register while the next frame
//   is taken; the following bin waits until that register is emptied
// ----------------------------------------------------------------------------
module three_band_level_meter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // left_sample, right_sample
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata,   // peak_envelope, low_level, mid_level,
                                        // high_level, bin_sequence
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  tblm_pkg::cmd_t    cmd;
  tblm_pkg::status_t status;
  logic [12:0]       fpb_q;
  logic [15:0]       decay_q;
  logic [23:0]       recip_q;
  logic              wr_en;
  logic [1:0]        ridx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign ridx   = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpb_q   <= 13'd294;
      decay_q <= 16'd64212;
      recip_q <= 24'd57065;
    end else if (wr_en) begin
      case (ridx)
        tblm_pkg::REG_FRAMES_PER_BIN: fpb_q   <= pwdata[12:0];
        tblm_pkg::REG_ENVELOPE_DECAY: decay_q <= pwdata[15:0];
        tblm_pkg::REG_BIN_RECIPROCAL: recip_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      tblm_pkg::REG_FRAMES_PER_BIN: prdata = {19'd0, fpb_q};
      tblm_pkg::REG_ENVELOPE_DECAY: prdata = {16'd0, decay_q};
      tblm_pkg::REG_BIN_RECIPROCAL: prdata = {8'd0, recip_q};
      default:                      prdata = '0;
    endcase
  end

  tblm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tblm_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .frames_per_bin_i (fpb_q),
    .envelope_decay_i (decay_q),
    .bin_reciprocal_i (recip_q),
    .samples_i        (s_axis_tdata),
    .status_o         (status),
    .result_o         (m_axis_tdata)
  );

  // one frame in flight
  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("frame accepted while previous frame in progress");

  // frame counter never passes the largest bin
  a_fc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.fc < 13'd4096)
    else $error("frame counter out of range");

  // a stalled bin holds its transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("bin dropped or changed while stalled");

  // no new frame while a bin is being loaded
  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !s_axis_tready)
    else $error("bin emitted while frame input open");

endmodule

>>> hdl/tblm_ctrl.sv
// ----------------------------------------------------------------------------
// tblm_ctrl
// sequencer: eight biquads per frame on the shared multiplier, then bin output
// ----------------------------------------------------------------------------
module tblm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tblm_pkg::status_t status_i,
  output tblm_pkg::cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_BQ     = 7'b0000010,
    ST_BQ_FIN = 7'b0000100,
    ST_CHECK  = 7'b0001000,
    ST_ENV    = 7'b0010000,
    ST_LVL    = 7'b0100000,
    ST_PUSH   = 7'b1000000
  } state_e;

  state_e      state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic [2:0]  filt_q, filt_d;
  logic [1:0]  band_q, band_d;
  logic        ovld_q, ovld_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    filt_d     = filt_q;
    band_d     = band_q;
    cmd_o      = '0;
    cmd_o.op   = tblm_pkg::OP_BQ_HI;
    cmd_o.filt = filt_q;
    cmd_o.band = band_q;
    cmd_o.tap  = step_q[3:1];
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_BQ;
          step_d     = '0;
          filt_d     = '0;
        end
      end
      ST_BQ: begin
        if (step_q < 4'(tblm_pkg::BQ_STEPS)) begin
          cmd_o.mul_en = 1'b1;
          cmd_o.op     = step_q[0] ? tblm_pkg::OP_BQ_LO : tblm_pkg::OP_BQ_HI;
          cmd_o.clr    = (step_q == '0);
          cmd_o.rnd    = (step_q == '0);
          step_d       = step_q + 4'd1;
        end else begin
          state_d = ST_BQ_FIN;
        end
      end
      ST_BQ_FIN: begin
        cmd_o.bq_fin = 1'b1;
        step_d       = '0;
        if (filt_q == 3'd7) begin
          state_d = ST_CHECK;
        end else begin
          filt_d  = filt_q + 3'd1;
          state_d = ST_BQ;
        end
      end
      ST_CHECK: begin
        step_d = '0;
        band_d = '0;
        if (status_i.bin_done) begin
          state_d = ST_ENV;
        end else begin
          cmd_o.fc_inc = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_ENV: begin
        cmd_o.op = tblm_pkg::OP_ENV;
        step_d   = step_q + 4'd1;
        if (step_q == 4'd0) begin
          cmd_o.mul_en = 1'b1;
          cmd_o.clr    = 1'b1;
        end else if (step_q == 4'd2) begin
          cmd_o.env_fin = 1'b1;
          step_d        = '0;
          state_d       = ST_LVL;
        end
      end
      ST_LVL: begin
        step_d = step_q + 4'd1;
        if (step_q == 4'd0) begin
          cmd_o.mul_en = 1'b1;
          cmd_o.clr    = 1'b1;
          cmd_o.op     = tblm_pkg::OP_SUM_HI;
        end else if (step_q == 4'd1) begin
          cmd_o.mul_en = 1'b1;
          cmd_o.op     = tblm_pkg::OP_SUM_LO;
        end else if (step_q == 4'd3) begin
          cmd_o.lvl_fin = 1'b1;
          step_d        = '0;
          if (band_q == 2'd2) begin
            state_d = ST_PUSH;
          end else begin
            band_d = band_q + 2'd1;
          end
        end
      end
      ST_PUSH: begin
        if (!ovld_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ovld_d = ovld_q;
    if (cmd_o.emit) begin
      ovld_d = 1'b1;
    end else if (out_ready_i) begin
      ovld_d = 1'b0;
    end
  end

  assign out_valid_o = ovld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      filt_q  <= '0;
      band_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      filt_q  <= filt_d;
      band_q  <= band_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

>>> hdl/tblm_dp.sv
// ----------------------------------------------------------------------------
// tblm_dp
// datapath: filter history, shared multiplier and accumulator, band sums
// ----------------------------------------------------------------------------
module tblm_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tblm_pkg::cmd_t                   cmd_i,
  input  logic [tblm_pkg::FC_W-1:0]        frames_per_bin_i,
  input  logic [15:0]                      envelope_decay_i,
  input  logic [23:0]                      bin_reciprocal_i,
  input  logic [2*tblm_pkg::SMP_W-1:0]     samples_i,
  output tblm_pkg::status_t                status_o,
  output logic [127:0]                     result_o
);

  localparam logic signed [tblm_pkg::SIG_W-1:0] SIG_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [tblm_pkg::SIG_W-1:0] SIG_MIN = {1'b1, {39{1'b0}}};

  logic signed [tblm_pkg::SMP_W-1:0]  smp_q [2];
  logic [30:0]                        peak_q;
  logic signed [tblm_pkg::SIG_W-1:0]  hist_q [32];
  logic signed [tblm_pkg::SIG_W-1:0]  mid_q;
  logic signed [tblm_pkg::ACC_W-1:0]  acc_q;
  logic signed [tblm_pkg::PROD_W-1:0] prod_q;
  logic [1:0]                         psh_q;
  logic                               pvld_q;
  logic [tblm_pkg::SUM_W-1:0]         sum_q [3];
  logic [tblm_pkg::LVL_W-1:0]         lvl_q [3];
  logic [tblm_pkg::LVL_W-1:0]         env_q;
  logic [tblm_pkg::FC_W-1:0]          fc_q;
  logic [31:0]                        bins_q;
  logic [127:0]                       res_q;

  logic [1:0]                         f;
  logic                               ch;
  logic signed [tblm_pkg::SIG_W-1:0]  x, v;
  logic [4:0]                         hidx;
  logic [2:0]                         tap_m1;
  logic signed [tblm_pkg::COEF_W-1:0] mul_a;
  logic signed [tblm_pkg::MB_W-1:0]   mul_b;
  logic [1:0]                         msh;
  logic signed [tblm_pkg::ACC_W-1:0]  term;
  logic signed [44:0]                 ysh;
  logic signed [tblm_pkg::SIG_W-1:0]  y;
  logic [tblm_pkg::SIG_W-1:0]         ay;
  logic [1:0]                         bidx;
  logic                               bhit;
  logic [tblm_pkg::SUM_W:0]           sadd;
  logic [32:0]                        a0, a1;
  logic [30:0]                        p0, p1, pmax;
  logic [tblm_pkg::LVL_W-1:0]         pk, dec, envn;
  logic [42:0]                        lv;
  logic [tblm_pkg::FC_W-1:0]          lim, fc_n;

  assign f      = cmd_i.filt[1:0];
  assign ch     = cmd_i.filt[2];
  assign x      = (f == 2'd2) ? mid_q : tblm_pkg::SIG_W'(smp_q[ch]);
  assign tap_m1 = cmd_i.tap - 3'd1;
  assign hidx   = {cmd_i.filt, tap_m1[1:0]};
  assign v      = (cmd_i.tap == 3'd0) ? x : hist_q[hidx];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    msh   = 2'd0;
    case (cmd_i.op)
      tblm_pkg::OP_BQ_HI: begin
        mul_a = tblm_pkg::coef(f, cmd_i.tap);
        mul_b = {v[39], v[39:16]};
        msh   = 2'd1;
      end
      tblm_pkg::OP_BQ_LO: begin
        mul_a = tblm_pkg::coef(f, cmd_i.tap);
        mul_b = {9'd0, v[15:0]};
      end
      tblm_pkg::OP_SUM_HI: begin
        mul_a = {17'd0, sum_q[cmd_i.band][47:32]};
        mul_b = {1'b0, bin_reciprocal_i};
        msh   = 2'd2;
      end
      tblm_pkg::OP_SUM_LO: begin
        mul_a = {1'b0, sum_q[cmd_i.band][31:0]};
        mul_b = {1'b0, bin_reciprocal_i};
      end
      tblm_pkg::OP_ENV: begin
        mul_a = {9'd0, env_q};
        mul_b = {9'd0, envelope_decay_i};
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_comb begin
    term = tblm_pkg::ACC_W'(prod_q);
    case (psh_q)
      2'd1:    term = term <<< 16;
      2'd2:    term = term <<< 32;
      default: term = term;
    endcase
  end

  // biquad output: round, then saturate to the history range
  assign ysh = acc_q[74:30];
  always_comb begin
    if (ysh[44:39] != {6{ysh[39]}}) begin
      y = ysh[44] ? SIG_MIN : SIG_MAX;
    end else begin
      y = ysh[39:0];
    end
  end
  assign ay = y[39] ? tblm_pkg::SIG_W'(-y) : y;

  always_comb begin
    bhit = 1'b1;
    bidx = 2'd0;
    case (f)
      2'd0:    bidx = 2'd0;
      2'd2:    bidx = 2'd1;
      2'd3:    bidx = 2'd2;
      default: bhit = 1'b0;
    endcase
  end
  assign sadd = {1'b0, sum_q[bidx]} + (tblm_pkg::SUM_W + 1)'(ay);

  // peak of both channels, negative full scale clips
  assign a0   = smp_q[0][31] ? 33'(-$signed({smp_q[0][31], smp_q[0]})) : 33'(smp_q[0]);
  assign a1   = smp_q[1][31] ? 33'(-$signed({smp_q[1][31], smp_q[1]})) : 33'(smp_q[1]);
  assign p0   = a0[32:31] != 2'd0 ? {31{1'b1}} : a0[30:0];
  assign p1   = a1[32:31] != 2'd0 ? {31{1'b1}} : a1[30:0];
  assign pmax = (p0 > p1) ? p0 : p1;

  assign pk   = peak_q[30:7];
  assign dec  = acc_q[39:16];
  assign envn = (pk > dec) ? pk : dec;
  assign lv   = acc_q[74:32];

  always_comb begin
    lim = frames_per_bin_i;
    if (frames_per_bin_i == '0) begin
      lim = tblm_pkg::FC_W'(1);
    end else if (frames_per_bin_i > tblm_pkg::FC_W'(tblm_pkg::MAX_FRAMES)) begin
      lim = tblm_pkg::FC_W'(tblm_pkg::MAX_FRAMES);
    end
  end
  assign fc_n              = fc_q + tblm_pkg::FC_W'(1);
  assign status_o.bin_done = (fc_n >= lim);
  assign status_o.fc       = fc_q;
  assign result_o          = res_q;

  // sample capture happens in the cycle before the peak update
  logic peak_upd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      smp_q[0] <= samples_i[31:0];
      smp_q[1] <= samples_i[63:32];
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
      psh_q  <= msh;
    end
    if (cmd_i.emit) begin
      res_q <= {bins_q, lvl_q[2], lvl_q[1], lvl_q[0], env_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) begin
        hist_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= '0;
        lvl_q[i] <= '0;
      end
      mid_q      <= '0;
      acc_q      <= '0;
      pvld_q     <= 1'b0;
      peak_q     <= '0;
      env_q      <= '0;
      fc_q       <= '0;
      bins_q     <= '0;
      peak_upd_q <= 1'b0;
    end else begin
      pvld_q     <= cmd_i.mul_en;
      peak_upd_q <= cmd_i.load;
      if (peak_upd_q && pmax > peak_q) begin
        peak_q <= pmax;
      end
      if (cmd_i.clr) begin
        acc_q <= cmd_i.rnd ? tblm_pkg::ACC_W'(1) <<< (tblm_pkg::COEF_FRAC - 1) : '0;
      end else if (pvld_q) begin
        acc_q <= acc_q + term;
      end
      if (cmd_i.bq_fin) begin
        hist_q[{cmd_i.filt, 2'd1}] <= hist_q[{cmd_i.filt, 2'd0}];
        hist_q[{cmd_i.filt, 2'd0}] <= x;
        hist_q[{cmd_i.filt, 2'd3}] <= hist_q[{cmd_i.filt, 2'd2}];
        hist_q[{cmd_i.filt, 2'd2}] <= y;
        if (f == 2'd1) begin
          mid_q <= y;
        end
        if (bhit) begin
          sum_q[bidx] <= sadd[tblm_pkg::SUM_W] ? {tblm_pkg::SUM_W{1'b1}}
                                               : sadd[tblm_pkg::SUM_W-1:0];
        end
      end
      if (cmd_i.env_fin) begin
        env_q <= envn;
      end
      if (cmd_i.lvl_fin) begin
        lvl_q[cmd_i.band] <= (lv[42:24] != '0) ? {tblm_pkg::LVL_W{1'b1}} : lv[23:0];
      end
      if (cmd_i.fc_inc) begin
        fc_q <= fc_n;
      end
      if (cmd_i.emit) begin
        bins_q <= bins_q + 32'd1;
        peak_q <= '0;
        fc_q   <= '0;
        for (int i = 0; i < 3; i++) begin
          sum_q[i] <= '0;
        end
      end
    end
  end

endmodule
